/* hw/rtl/pps_pkg.sv */
// ---------------------------------------------------------------------------
// pps_pkg: shared types and constants for the polyline point simplifier
// Tolerance register format, point phase codes, multiplier sequencing codes
// and the tag that travels with each product of the shared multiplier.
// ---------------------------------------------------------------------------
package pps_pkg;

   localparam int          TOL_WIDTH = 24;
   localparam logic [23:0] TOL_RESET = 24'd3775;

   // what the block holds between points
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_ANCHOR = 2'd1;
   localparam logic [1:0] PHASE_MIDDLE = 2'd2;

   // slot within one axis during the coordinate products
   localparam logic [1:0] KIND_DD = 2'd0;
   localparam logic [1:0] KIND_WW = 2'd1;
   localparam logic [1:0] KIND_EE = 2'd2;
   localparam logic [1:0] KIND_WD = 2'd3;

   // term of the exact compare, four limb products each
   localparam logic [1:0] TERM_WW_DD  = 2'd0;
   localparam logic [1:0] TERM_TOL_DD = 2'd1;
   localparam logic [1:0] TERM_WD_WD  = 2'd2;

   // both product runs issue twelve multiplies
   localparam logic [3:0] LAST_OP = 4'd11;

   typedef enum logic [2:0] {
      DST_DD,
      DST_WW,
      DST_EE,
      DST_WD,
      DST_ACC
   } acc_dest_type;

   typedef struct packed {
      logic         valid;
      acc_dest_type dest;
      logic         neg;
      logic [1:0]   limb_shift;
   } mul_tag_type;

endpackage

/* hw/rtl/polyline_point_simplify_top.sv */
// ---------------------------------------------------------------------------
// polyline_point_simplify_top: streaming removal of nearly collinear points
// Takes 3D polyline points and emits the simplified polyline. The first and
// the last point of a run always pass. An interior point is dropped when its
// squared distance to the segment from the last kept point to the following
// point is below csr tolerance_sq (clamped segment parameter, exact integer
// arithmetic, no division). All products come from one shared multiplier of
// (COORD_WIDTH+1) x (COORD_WIDTH+1) bits: 12 coordinate products for each
// point from the third on, then 12 limb products when the exact
// cross-multiplied compare is needed rather than a clamp case. A result is
// held in an output register, so the next point is taken while it waits.
// ---------------------------------------------------------------------------
module polyline_point_simplify_top #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // pos_x, pos_y, pos_z from bit 0 up, zero padded to whole bytes
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]          req_tdata,
   input  logic                                        req_tlast,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // out_x, out_y, out_z from bit 0 up, zero padded to whole bytes
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]          rsp_tdata,
   output logic                                        rsp_tlast,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [pps_pkg::TOL_WIDTH-1:0]               csr_data
);

   localparam int CW     = COORD_WIDTH;
   localparam int L      = CW + 1;
   localparam int PW     = 2 * L;
   localparam int ACC_W  = 4 * L + 2;
   localparam int DATA_W = ((3 * CW + 7) / 8) * 8;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIFF,
      S_MUL,
      S_DRAIN,
      S_DECIDE,
      S_WIDE,
      S_WDRAIN,
      S_CMP,
      S_EMIT_MID,
      S_EMIT_PT
   } state_type;

   state_type                       state_ff;
   logic [1:0]                      phase_ff;
   logic [3:0]                      cnt_ff;
   logic [pps_pkg::TOL_WIDTH-1:0]   tol_ff;
   logic [CW-1:0]                   anchor_ff [3];
   logic [CW-1:0]                   middle_ff [3];
   logic [CW-1:0]                   pt_ff [3];
   logic                            last_ff;
   logic                            rsp_valid_ff;
   logic [CW-1:0]                   rsp_pt_ff [3];
   logic                            rsp_last_ff;

   logic [CW-1:0]                   req_pt [3];
   logic [CW:0]                     d_dif [3];
   logic [CW:0]                     w_dif [3];
   logic [CW:0]                     e_dif [3];
   logic [CW-1:0]                   dmag_in [3];
   logic [CW-1:0]                   wmag_in [3];
   logic [CW-1:0]                   emag_in [3];
   logic [CW-1:0]                   dmag_ff [3];
   logic [CW-1:0]                   wmag_ff [3];
   logic [CW-1:0]                   emag_ff [3];
   logic                            dneg_ff [3];
   logic                            wneg_ff [3];

   logic [1:0]                      axis;
   logic [L-1:0]                    mul_a;
   logic [L-1:0]                    mul_b;
   logic [PW-1:0]                   wide_x;
   logic [PW-1:0]                   wide_y;
   pps_pkg::mul_tag_type            tag_in;
   pps_pkg::mul_tag_type            tag_ff;
   logic [PW-1:0]                   prod_ff;
   logic [ACC_W-1:0]                acc_term;

   logic [PW-1:0]                   dd_ff;
   logic [PW-1:0]                   ww_ff;
   logic [PW-1:0]                   ee_ff;
   logic signed [PW:0]              wd_ff;
   logic signed [ACC_W-1:0]         acc_ff;

   logic [PW-1:0]                   tol_ext;
   logic [PW-1:0]                   wd_mag;
   logic                            dd_zero;
   logic                            wd_pos;
   logic                            wd_ge_dd;
   logic                            need_wide;
   logic [PW-1:0]                   clamp_dist;
   logic                            drop_in;
   logic                            out_free;
   logic                            rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'({rsp_pt_ff[2], rsp_pt_ff[1], rsp_pt_ff[0]});
   assign rsp_tlast  = rsp_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = out_free && (state_ff inside {S_EMIT_MID, S_EMIT_PT});

   // coordinate differences, magnitude and sign per axis
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         req_pt[k]  = req_tdata[k*CW +: CW];
         d_dif[k]   = {pt_ff[k][CW-1], pt_ff[k]} - {anchor_ff[k][CW-1], anchor_ff[k]};
         w_dif[k]   = {middle_ff[k][CW-1], middle_ff[k]} - {anchor_ff[k][CW-1], anchor_ff[k]};
         e_dif[k]   = {middle_ff[k][CW-1], middle_ff[k]} - {pt_ff[k][CW-1], pt_ff[k]};
         dmag_in[k] = d_dif[k][CW] ? CW'(-d_dif[k]) : d_dif[k][CW-1:0];
         wmag_in[k] = w_dif[k][CW] ? CW'(-w_dif[k]) : w_dif[k][CW-1:0];
         emag_in[k] = e_dif[k][CW] ? CW'(-e_dif[k]) : e_dif[k][CW-1:0];
      end
   end

   assign tol_ext  = PW'(tol_ff);
   assign wd_mag   = wd_ff[PW-1:0];
   assign dd_zero  = (dd_ff == '0);
   assign wd_pos   = !wd_ff[PW] && (wd_ff != '0);
   assign wd_ge_dd = (wd_ff >= $signed({1'b0, dd_ff}));
   assign need_wide  = !dd_zero && wd_pos && !wd_ge_dd;
   assign clamp_dist = (dd_zero || !wd_pos) ? ww_ff : ee_ff;
   // exact form: drop when tol*dd + wd^2 - ww*dd > 0
   assign drop_in   = (state_ff == S_CMP) ? (acc_ff > 0) : (clamp_dist < tol_ext);

   // operand select for the shared multiplier
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      wide_x = '0;
      wide_y = '0;
      tag_in = '0;
      axis   = cnt_ff[3:2];
      case (state_ff)
         S_MUL: begin
            tag_in.valid = 1'b1;
            case (cnt_ff[1:0])
               pps_pkg::KIND_DD: begin
                  mul_a       = {1'b0, dmag_ff[axis]};
                  mul_b       = {1'b0, dmag_ff[axis]};
                  tag_in.dest = pps_pkg::DST_DD;
               end
               pps_pkg::KIND_WW: begin
                  mul_a       = {1'b0, wmag_ff[axis]};
                  mul_b       = {1'b0, wmag_ff[axis]};
                  tag_in.dest = pps_pkg::DST_WW;
               end
               pps_pkg::KIND_EE: begin
                  mul_a       = {1'b0, emag_ff[axis]};
                  mul_b       = {1'b0, emag_ff[axis]};
                  tag_in.dest = pps_pkg::DST_EE;
               end
               default: begin
                  mul_a       = {1'b0, wmag_ff[axis]};
                  mul_b       = {1'b0, dmag_ff[axis]};
                  tag_in.dest = pps_pkg::DST_WD;
                  tag_in.neg  = dneg_ff[axis] ^ wneg_ff[axis];
               end
            endcase
         end
         S_WIDE: begin
            tag_in.valid      = 1'b1;
            tag_in.dest       = pps_pkg::DST_ACC;
            tag_in.limb_shift = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
            case (cnt_ff[3:2])
               pps_pkg::TERM_WW_DD: begin
                  wide_x     = ww_ff;
                  wide_y     = dd_ff;
                  tag_in.neg = 1'b1;
               end
               pps_pkg::TERM_TOL_DD: begin
                  wide_x = tol_ext;
                  wide_y = dd_ff;
               end
               default: begin
                  wide_x = wd_mag;
                  wide_y = wd_mag;
               end
            endcase
            mul_a = cnt_ff[1] ? wide_x[PW-1:L] : wide_x[L-1:0];
            mul_b = cnt_ff[0] ? wide_y[PW-1:L] : wide_y[L-1:0];
         end
         default: ;
      endcase
   end

   always_comb begin
      case (tag_ff.limb_shift)
         2'd0:    acc_term = ACC_W'(prod_ff);
         2'd1:    acc_term = ACC_W'(prod_ff) << L;
         default: acc_term = ACC_W'(prod_ff) << (2 * L);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   // multiplier, accumulators and difference registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (state_ff == S_DIFF) begin
         for (int k = 0; k < 3; k++) begin
            dmag_ff[k] <= dmag_in[k];
            wmag_ff[k] <= wmag_in[k];
            emag_ff[k] <= emag_in[k];
            dneg_ff[k] <= d_dif[k][CW];
            wneg_ff[k] <= w_dif[k][CW];
         end
         dd_ff <= '0;
         ww_ff <= '0;
         ee_ff <= '0;
         wd_ff <= '0;
      end else if (state_ff == S_DECIDE) begin
         acc_ff <= '0;
      end else if (tag_ff.valid) begin
         case (tag_ff.dest)
            pps_pkg::DST_DD: dd_ff <= dd_ff + prod_ff;
            pps_pkg::DST_WW: ww_ff <= ww_ff + prod_ff;
            pps_pkg::DST_EE: ee_ff <= ee_ff + prod_ff;
            pps_pkg::DST_WD: wd_ff <= tag_ff.neg ? wd_ff - $signed({1'b0, prod_ff})
                                                 : wd_ff + $signed({1'b0, prod_ff});
            default:         acc_ff <= tag_ff.neg ? acc_ff - $signed(acc_term)
                                                  : acc_ff + $signed(acc_term);
         endcase
      end
   end

   // sequencer, held points and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= pps_pkg::PHASE_FIRST;
         cnt_ff       <= '0;
         tol_ff       <= pps_pkg::TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            tol_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  pt_ff   <= req_pt;
                  last_ff <= req_tlast;
                  case (phase_ff)
                     pps_pkg::PHASE_ANCHOR: begin
                        if (req_tlast) begin
                           phase_ff <= pps_pkg::PHASE_FIRST;
                           state_ff <= S_EMIT_PT;
                        end else begin
                           middle_ff <= req_pt;
                           phase_ff  <= pps_pkg::PHASE_MIDDLE;
                        end
                     end
                     pps_pkg::PHASE_MIDDLE: begin
                        if (req_tlast) begin
                           phase_ff <= pps_pkg::PHASE_FIRST;
                        end
                        state_ff <= S_DIFF;
                     end
                     default: begin
                        if (req_tlast) begin
                           phase_ff <= pps_pkg::PHASE_FIRST;
                        end else begin
                           anchor_ff <= req_pt;
                           phase_ff  <= pps_pkg::PHASE_ANCHOR;
                        end
                        state_ff <= S_EMIT_PT;
                     end
                  endcase
               end
            end
            S_DIFF: begin
               cnt_ff   <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               if (cnt_ff == pps_pkg::LAST_OP) begin
                  state_ff <= S_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            S_DRAIN: begin
               state_ff <= S_DECIDE;
            end
            S_WIDE: begin
               if (cnt_ff == pps_pkg::LAST_OP) begin
                  state_ff <= S_WDRAIN;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            S_WDRAIN: begin
               state_ff <= S_CMP;
            end
            S_DECIDE, S_CMP: begin
               if (state_ff == S_DECIDE && need_wide) begin
                  cnt_ff   <= '0;
                  state_ff <= S_WIDE;
               end else if (!drop_in) begin
                  state_ff <= S_EMIT_MID;
               end else begin
                  middle_ff <= pt_ff;
                  state_ff  <= last_ff ? S_EMIT_PT : S_IDLE;
               end
            end
            S_EMIT_MID: begin
               if (out_free) begin
                  rsp_pt_ff    <= middle_ff;
                  rsp_last_ff  <= 1'b0;
                  anchor_ff    <= middle_ff;
                  middle_ff    <= pt_ff;
                  state_ff     <= last_ff ? S_EMIT_PT : S_IDLE;
               end
            end
            S_EMIT_PT: begin
               if (out_free) begin
                  rsp_pt_ff    <= pt_ff;
                  rsp_last_ff  <= last_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // no product may still be in flight once the sequencer is back at idle
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !tag_ff.valid)
      else $error("multiplier product in flight at idle");

   // the exact compare only runs inside the unclamped segment range
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WIDE |-> wd_pos && (wd_mag < dd_ff))
      else $error("exact compare entered outside the segment interior");

   // a new result only appears from one of the emit steps
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT_MID) || $past(state_ff == S_EMIT_PT))
      else $error("result transaction raised outside an emit step");

endmodule

/* verif/polyline_point_simplify_top_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// polyline_point_simplify_top_tb: self-checking bench for the point simplifier
// Streams polylines into the block and checks every kept point against an
// exact in-bench predictor of the clamped segment distance test or a listed
// row. A short table of hand-picked points comes first. Random polylines
// follow under several tolerance settings, with random stalls on both streams,
// one long output hold-off and one stretch with no stalls at all.
// ---------------------------------------------------------------------------
module polyline_point_simplify_top_tb;

   localparam int CW                = 24;
   localparam int CYCLE_LIMIT       = 1000000;
   localparam int TAIL_CYCLES       = 40;
   localparam int NUM_SETTINGS      = 6;
   localparam int ITEMS_PER_SETTING = 290;
   localparam int NUM_ROWS          = 25;

   localparam logic signed [CW-1:0] CMAX = 24'sh7FFFFF;
   localparam logic signed [CW-1:0] CMIN = 24'sh800000;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 last;
   } point_type;

   localparam point_type NO_POINT = '0;

   typedef enum logic {
      CHECK_PREDICTED,
      CHECK_LISTED
   } check_src_type;

   typedef struct packed {
      point_type     pt;
      check_src_type src;
      logic [1:0]    n_kept;
      point_type     kept0;
      point_type     kept1;
   } row_type;

   // hand-picked points; listed rows carry the kept points directly
   row_type point_rows [NUM_ROWS] = '{
      // single point paths, including the coordinate extremes
      '{'{24'sd0, 24'sd0, 24'sd0, 1'b1}, CHECK_LISTED, 2'd1,
        '{24'sd0, 24'sd0, 24'sd0, 1'b1}, NO_POINT},
      '{'{CMAX, CMIN, CMAX, 1'b1}, CHECK_LISTED, 2'd1,
        '{CMAX, CMIN, CMAX, 1'b1}, NO_POINT},
      // two point path
      '{'{CMIN, CMIN, CMIN, 1'b0}, CHECK_LISTED, 2'd1,
        '{CMIN, CMIN, CMIN, 1'b0}, NO_POINT},
      '{'{CMAX, CMAX, CMAX, 1'b1}, CHECK_LISTED, 2'd1,
        '{CMAX, CMAX, CMAX, 1'b1}, NO_POINT},
      // exact collinear middle point drops
      '{'{24'sd0, 24'sd0, 24'sd0, 1'b0}, CHECK_LISTED, 2'd1,
        '{24'sd0, 24'sd0, 24'sd0, 1'b0}, NO_POINT},
      '{'{24'sd4096, 24'sd4096, 24'sd4096, 1'b0}, CHECK_LISTED, 2'd0,
        NO_POINT, NO_POINT},
      '{'{24'sd8192, 24'sd8192, 24'sd8192, 1'b1}, CHECK_LISTED, 2'd1,
        '{24'sd8192, 24'sd8192, 24'sd8192, 1'b1}, NO_POINT},
      // far middle point kept, last point gives two transactions
      '{'{24'sd0, 24'sd0, 24'sd0, 1'b0}, CHECK_LISTED, 2'd1,
        '{24'sd0, 24'sd0, 24'sd0, 1'b0}, NO_POINT},
      '{'{24'sd0, 24'sd40960, 24'sd0, 1'b0}, CHECK_LISTED, 2'd0,
        NO_POINT, NO_POINT},
      '{'{24'sd81920, 24'sd0, 24'sd0, 1'b1}, CHECK_LISTED, 2'd2,
        '{24'sd0, 24'sd40960, 24'sd0, 1'b0}, '{24'sd81920, 24'sd0, 24'sd0, 1'b1}},
      // segment that collapses onto the anchor
      '{'{24'sd100, 24'sd100, 24'sd100, 1'b0}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT},
      '{'{24'sd300, 24'sd100, 24'sd100, 1'b0}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT},
      '{'{24'sd100, 24'sd100, 24'sd100, 1'b0}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT},
      '{'{24'sd300, 24'sd100, 24'sd100, 1'b1}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT},
      // middle point past the segment end
      '{'{24'sd0, 24'sd0, 24'sd0, 1'b0}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT},
      '{'{24'sd10000, 24'sd0, 24'sd0, 1'b0}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT},
      '{'{24'sd5000, 24'sd0, 24'sd0, 1'b0}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT},
      '{'{CMIN, 24'sd0, 24'sd0, 1'b1}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT},
      // offsets just under and just over the reset tolerance
      '{'{24'sd0, 24'sd0, 24'sd0, 1'b0}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT},
      '{'{24'sd2048, 24'sd60, 24'sd0, 1'b0}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT},
      '{'{24'sd4096, 24'sd0, 24'sd0, 1'b0}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT},
      '{'{24'sd8192, 24'sd0, 24'sd0, 1'b1}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT},
      '{'{24'sd0, 24'sd0, 24'sd0, 1'b0}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT},
      '{'{24'sd2048, 24'sd62, 24'sd0, 1'b0}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT},
      '{'{24'sd4096, 24'sd0, 24'sd0, 1'b1}, CHECK_PREDICTED, 2'd0, NO_POINT, NO_POINT}
   };

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [71:0]   req_tdata  = '0;
   logic          req_tlast  = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [71:0]   rsp_tdata;
   logic          rsp_tlast;
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   logic [23:0]   csr_data   = '0;

   // predictor state
   logic [23:0]   tol_sq = pps_pkg::TOL_RESET;
   point_type     anchor_pt = '0;
   point_type     middle_pt = '0;
   logic [1:0]    path_phase = pps_pkg::PHASE_FIRST;

   point_type     kept_points [$];

   logic          hold_rsp = 1'b0;
   logic          calm     = 1'b0;

   int            cycle_count     = 0;
   int            items_sent      = 0;
   int            paths_sent      = 0;
   int            results_checked = 0;
   int            mismatches      = 0;
   int            n_dropped       = 0;
   int            n_degenerate    = 0;
   int            n_behind        = 0;
   int            n_past_end      = 0;
   int            n_exact         = 0;
   int            n_settings      = 0;

   polyline_point_simplify_top #(
      .COORD_WIDTH (CW)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // squared distance from the middle point to segment anchor..p, below tolerance
   function automatic bit middle_is_dropped(input point_type p);
      logic signed [CW-1:0] pc [3];
      logic signed [CW-1:0] ac [3];
      logic signed [CW-1:0] mc [3];
      logic signed [CW+1:0] d, w, e;
      logic signed [63:0]   dd, ww, ee, wd;
      logic [127:0]         lhs, rhs;
      logic [63:0]          seg_dist;
      pc = '{p.x, p.y, p.z};
      ac = '{anchor_pt.x, anchor_pt.y, anchor_pt.z};
      mc = '{middle_pt.x, middle_pt.y, middle_pt.z};
      dd = '0;
      ww = '0;
      ee = '0;
      wd = '0;
      for (int i = 0; i < 3; i++) begin
         d  = pc[i] - ac[i];
         w  = mc[i] - ac[i];
         e  = mc[i] - pc[i];
         dd = dd + d * d;
         ww = ww + w * w;
         ee = ee + e * e;
         wd = wd + w * d;
      end
      if (dd == 0) begin
         n_degenerate++;
         seg_dist = ww;
      end else if (wd <= 0) begin
         n_behind++;
         seg_dist = ww;
      end else if (wd >= dd) begin
         n_past_end++;
         seg_dist = ee;
      end else begin
         // ww - wd^2/dd < tol, multiplied through by dd
         n_exact++;
         lhs = {64'd0, ww} * {64'd0, dd};
         rhs = {104'd0, tol_sq} * {64'd0, dd} + {64'd0, wd} * {64'd0, wd};
         return lhs < rhs;
      end
      return seg_dist < {40'd0, tol_sq};
   endfunction

   // advances the path state by one point, returns the number of kept points
   function automatic int simplify_step(input point_type p, output point_type k0,
                                        output point_type k1);
      int n;
      n  = 0;
      k0 = NO_POINT;
      k1 = NO_POINT;
      case (path_phase)
         pps_pkg::PHASE_ANCHOR: begin
            if (p.last) begin
               k0 = p;
               n = 1;
               path_phase = pps_pkg::PHASE_FIRST;
            end else begin
               middle_pt = p;
               path_phase = pps_pkg::PHASE_MIDDLE;
            end
         end
         pps_pkg::PHASE_MIDDLE: begin
            if (!middle_is_dropped(p)) begin
               k0 = middle_pt;
               k0.last = 1'b0;
               anchor_pt = middle_pt;
               n = 1;
            end else begin
               n_dropped++;
            end
            middle_pt = p;
            if (p.last) begin
               if (n == 0) k0 = p;
               else k1 = p;
               n++;
               path_phase = pps_pkg::PHASE_FIRST;
            end
         end
         default: begin
            k0 = p;
            n = 1;
            if (p.last) begin
               path_phase = pps_pkg::PHASE_FIRST;
            end else begin
               anchor_pt = p;
               path_phase = pps_pkg::PHASE_ANCHOR;
            end
         end
      endcase
      return n;
   endfunction

   // appends one expected point to the tail of the pending list
   function automatic void add_expected(input point_type p);
      kept_points.insert(kept_points.size(), p);
   endfunction

   task automatic send_point(input point_type pt);
      int gap;
      if (!calm && $urandom_range(0, 99) < 11) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pt.z, pt.y, pt.x};
      req_tlast  <= pt.last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_predicted(input point_type pt);
      point_type k0, k1;
      int        n;
      send_point(pt);
      n = simplify_step(pt, k0, k1);
      if (n > 0) add_expected(k0);
      if (n > 1) add_expected(k1);
   endtask

   task automatic send_random_path();
      int        len, mode, sel, t, nmax;
      int        bx, by, bz, sx, sy, sz, sh;
      point_type pt;
      sel = $urandom_range(0, 99);
      if (sel < 6) len = 1;
      else if (sel < 12) len = 2;
      else len = $urandom_range(3, 16);
      mode = $urandom_range(0, 9);
      bx = int'($urandom_range(0, 8388608)) - 4194304;
      by = int'($urandom_range(0, 8388608)) - 4194304;
      bz = int'($urandom_range(0, 8388608)) - 4194304;
      sh = $urandom_range(0, 16);
      sx = int'($urandom_range(0, 2 << sh)) - (1 << sh);
      sy = int'($urandom_range(0, 2 << sh)) - (1 << sh);
      sz = int'($urandom_range(0, 2 << sh)) - (1 << sh);
      nmax = 1 << $urandom_range(0, 12);
      t = 0;
      for (int i = 0; i < len; i++) begin
         if (mode == 0) begin
            pt.x = 24'($urandom);
            pt.y = 24'($urandom);
            pt.z = 24'($urandom);
         end else if (mode == 1) begin
            // tiny cloud: repeated points and collapsed segments
            pt.x = 24'(int'($urandom_range(0, 16)) - 8);
            pt.y = 24'(int'($urandom_range(0, 16)) - 8);
            pt.z = 24'(int'($urandom_range(0, 16)) - 8);
         end else begin
            // points along a line with noise around the tolerance scale
            pt.x = 24'(bx + t * sx + int'($urandom_range(0, 2 * nmax)) - nmax);
            pt.y = 24'(by + t * sy + int'($urandom_range(0, 2 * nmax)) - nmax);
            pt.z = 24'(bz + t * sz + int'($urandom_range(0, 2 * nmax)) - nmax);
            sel = $urandom_range(0, 99);
            if (sel < 10) t = t - int'($urandom_range(1, 2));
            else if (sel >= 20) t = t + 1;
         end
         pt.last = (i == len - 1);
         send_predicted(pt);
      end
      paths_sent++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (kept_points.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tol_sq = value;
      n_settings++;
   endtask

   // output side: check each transaction and pick the next ready level
   always @(posedge clock) begin
      point_type exp_pt;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (kept_points.size() == 0) begin
            mismatches++;
            $display("%0t ns: result with nothing pending, got x=%0d y=%0d z=%0d last=%0b",
                     $time, $signed(rsp_tdata[23:0]), $signed(rsp_tdata[47:24]),
                     $signed(rsp_tdata[71:48]), rsp_tlast);
         end else begin
            exp_pt = kept_points.pop_front();
            if (exp_pt.x !== $signed(rsp_tdata[23:0])) begin
               mismatches++;
               $display("%0t ns: out_x expected %0d, got %0d", $time, exp_pt.x,
                        $signed(rsp_tdata[23:0]));
            end
            if (exp_pt.y !== $signed(rsp_tdata[47:24])) begin
               mismatches++;
               $display("%0t ns: out_y expected %0d, got %0d", $time, exp_pt.y,
                        $signed(rsp_tdata[47:24]));
            end
            if (exp_pt.z !== $signed(rsp_tdata[71:48])) begin
               mismatches++;
               $display("%0t ns: out_z expected %0d, got %0d", $time, exp_pt.z,
                        $signed(rsp_tdata[71:48]));
            end
            if (exp_pt.last !== rsp_tlast) begin
               mismatches++;
               $display("%0t ns: out_last expected %0b, got %0b", $time, exp_pt.last,
                        rsp_tlast);
            end
         end
      end
      if (hold_rsp) rsp_tready <= 1'b0;
      else if (calm) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 99) >= 11);
   end

   // long output hold-off while points keep coming, so the block backs up
   initial begin
      wait (items_sent >= 500);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               kept_points.size());
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < NUM_ROWS; r++) begin
         point_type k0, k1;
         if (point_rows[r].src == CHECK_LISTED) begin
            send_point(point_rows[r].pt);
            void'(simplify_step(point_rows[r].pt, k0, k1));
            if (point_rows[r].n_kept > 0) add_expected(point_rows[r].kept0);
            if (point_rows[r].n_kept > 1) add_expected(point_rows[r].kept1);
         end else begin
            send_predicted(point_rows[r].pt);
         end
      end
      paths_sent += 9;

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         logic [23:0] tol;
         int          first_item;
         case (s)
            0:       tol = 24'd0;
            1:       tol = 24'hFFFFFF;
            2:       tol = 24'($urandom);
            3:       tol = 24'd1 << $urandom_range(4, 23);
            4:       tol = 24'($urandom_range(0, 4095));
            default: tol = pps_pkg::TOL_RESET;
         endcase
         wait_for_results();
         write_tolerance(tol);
         calm <= (s == 4);
         first_item = items_sent;
         while (items_sent - first_item < ITEMS_PER_SETTING) send_random_path();
      end

      wait_for_results();
      $display("run: %0d points, %0d polylines, %0d tolerances, %0d kept points checked",
               items_sent, paths_sent, n_settings + 1, results_checked);
      $display("cases: %0d collapsed, %0d behind, %0d past end, %0d exact, %0d dropped",
               n_degenerate, n_behind, n_past_end, n_exact, n_dropped);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/pps_pkg.sv
hw/rtl/polyline_point_simplify_top.sv
verif/polyline_point_simplify_top_tb.sv
